/* hdl/mcpwm_pkg.sv */
// ----------------------------------------------------------------------------
// mcpwm_pkg
// Shared constants and types for the multi-channel PWM generator.
// ----------------------------------------------------------------------------
package mcpwm_pkg;

  localparam int unsigned CHANNELS     = 8;
  localparam int unsigned PERIOD_STEPS = 255;
  localparam int unsigned CHAN_W       = 3;
  localparam int unsigned DUTY_W       = 8;
  localparam int unsigned STEP_W       = 8;

  localparam logic [DUTY_W-1:0] DUTY_FORCE_LOW  = 8'd0;
  localparam logic [DUTY_W-1:0] DUTY_FORCE_HIGH = 8'd255;

  typedef enum logic {
    MODE_TICK  = 1'b0,
    MODE_WRITE = 1'b1
  } mode_e;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [CHAN_W-1:0] channel;
    mode_e             mode;
  } mcpwm_item_t;

  typedef struct packed {
    logic                running;
    logic                period_start;
    logic [CHANNELS-1:0] port_value;
  } mcpwm_result_t;

endpackage

/* hdl/mcpwm_core.sv */
// ----------------------------------------------------------------------------
// mcpwm_core
// Duty buffers, step counter and pin levels; one item updates them per cycle.
// ----------------------------------------------------------------------------
module mcpwm_core
  import mcpwm_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          item_valid_i,
  input  mcpwm_item_t   item_i,
  output mcpwm_result_t result_o
);

  logic [DUTY_W-1:0]   live_duty_q [CHANNELS];
  logic [DUTY_W-1:0]   live_duty_d [CHANNELS];
  logic [DUTY_W-1:0]   pend_duty_q [CHANNELS];
  logic [DUTY_W-1:0]   pend_duty_d [CHANNELS];
  logic [CHANNELS-1:0] live_active_q, live_active_d;
  logic [CHANNELS-1:0] pend_active_q, pend_active_d;
  logic [CHANNELS-1:0] force_high_q, force_high_d;
  logic [CHANNELS-1:0] force_low_q, force_low_d;
  logic                waiting_q, waiting_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [CHANNELS-1:0] pins_q, pins_d;
  logic                started;

  always_comb begin
    logic [CHANNELS-1:0] m;
    logic                is_force;
    logic                apply;
    logic                drive_en;
    logic [STEP_W:0]     next_step;

    pend_duty_d   = pend_duty_q;
    pend_active_d = pend_active_q;
    force_high_d  = force_high_q;
    force_low_d   = force_low_q;
    waiting_d     = waiting_q;
    live_duty_d   = live_duty_q;
    live_active_d = live_active_q;
    step_d        = step_q;
    pins_d        = pins_q;
    started       = 1'b0;
    apply         = 1'b0;
    drive_en      = 1'b0;
    m             = CHANNELS'(1) << item_i.channel;
    is_force      = (item_i.duty == DUTY_FORCE_LOW) || (item_i.duty == DUTY_FORCE_HIGH);
    next_step     = {1'b0, step_q} + (STEP_W+1)'(1);

    if (item_valid_i) begin
      if (item_i.mode == MODE_WRITE) begin
        if ({1'b0, item_i.channel} < (CHAN_W+1)'(CHANNELS)) begin
          if (is_force) begin
            pend_active_d                     = pend_active_q & ~m;
            pend_duty_d[item_i.channel[CHAN_W-1:0]] = '0;
            if (item_i.duty == DUTY_FORCE_LOW) begin
              force_low_d  = force_low_q | m;
              force_high_d = force_high_q & ~m;
            end else begin
              force_high_d = force_high_q | m;
              force_low_d  = force_low_q & ~m;
            end
          end else begin
            pend_duty_d[item_i.channel[CHAN_W-1:0]] = item_i.duty;
            pend_active_d = pend_active_q | m;
            force_low_d   = force_low_q & ~m;
            force_high_d  = force_high_q & ~m;
          end
          waiting_d = 1'b1;
          // idle: the new setting takes effect right away
          apply = (live_active_q == '0);
        end
      end else if (live_active_q != '0) begin
        drive_en = 1'b1;
        if (next_step >= (STEP_W+1)'(PERIOD_STEPS)) begin
          started = 1'b1;
          step_d  = '0;
          apply   = waiting_q;
        end else begin
          step_d = next_step[STEP_W-1:0];
        end
      end
    end

    if (apply) begin
      live_duty_d   = pend_duty_d;
      live_active_d = pend_active_d;
      pins_d        = (pins_q & ~force_low_d) | force_high_d;
      force_low_d   = '0;
      force_high_d  = '0;
      waiting_d     = 1'b0;
      step_d        = '0;
      drive_en      = 1'b1;
    end

    // eight parallel compares against the step now in effect
    if (drive_en) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (live_active_d[c]) begin
          pins_d[c] = (step_d < live_duty_d[c]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        live_duty_q[c] <= '0;
        pend_duty_q[c] <= '0;
      end
      live_active_q <= '0;
      pend_active_q <= '0;
      force_high_q  <= '0;
      force_low_q   <= '0;
      waiting_q     <= 1'b0;
      step_q        <= '0;
      pins_q        <= '0;
    end else begin
      live_duty_q   <= live_duty_d;
      pend_duty_q   <= pend_duty_d;
      live_active_q <= live_active_d;
      pend_active_q <= pend_active_d;
      force_high_q  <= force_high_d;
      force_low_q   <= force_low_d;
      waiting_q     <= waiting_d;
      step_q        <= step_d;
      pins_q        <= pins_d;
    end
  end

  assign result_o.port_value   = pins_d;
  assign result_o.period_start = started;
  assign result_o.running      = (live_active_d != '0);

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q < STEP_W'(PERIOD_STEPS))
    else $error("step counter out of range");

  a_idle_step_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (live_active_q == '0) |-> (step_q == '0))
    else $error("step advanced while no channel runs");

  a_wait_only_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    waiting_q |-> (live_active_q != '0))
    else $error("update left pending while idle");

endmodule

/* hdl/mcpwm_out.sv */
// ----------------------------------------------------------------------------
// mcpwm_out
// Result register and skid stage; a transfer can be taken while skid is empty.
// ----------------------------------------------------------------------------
module mcpwm_out
  import mcpwm_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mcpwm_result_t data_i,
  output logic          ready_o,
  output logic          valid_o,
  input  logic          pop_ready_i,
  output mcpwm_result_t data_o
);

  logic          out_valid_q, skid_valid_q;
  mcpwm_result_t out_data_q, skid_data_q;
  logic          pop;

  assign pop     = out_valid_q && pop_ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || pop) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= push_i;
        end
      end else if (push_i) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_data_q <= skid_valid_q ? skid_data_q : data_i;
    end else if (push_i) begin
      skid_data_q <= data_i;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry without output entry");

endmodule

/* hdl/multi_channel_pwm_generator.sv */
// ----------------------------------------------------------------------------
// multi_channel_pwm_generator
// Eight-channel PWM with double-buffered duty writes, driven by step ticks.
// ----------------------------------------------------------------------------
// Input stream: tuser selects the item kind (0 = step tick, 1 = duty write);
// tdata carries the channel index and the duty for a write. Each accepted
// transfer yields exactly one output transfer holding the pin levels, a
// period-start flag and a running flag.
// Each result is registered before it leaves the block.
// One item per cycle while the receiver keeps up; the eight duty compares run
// in parallel between the state registers and the result register.
// Duty 0 or 255 takes a channel out of PWM and forces its pin low or high;
// writes take effect at the next period start, or at once while no channel
// runs. A period is 255 ticks; the first period after start begins at step 0.
// Reset clears all duties, masks, the step counter and the pins.
// When the receiver stalls, one result waits in the output register and one
// more in a skid stage; s_axis_tready drops only once both are full.
// ----------------------------------------------------------------------------
module multi_channel_pwm_generator
  import mcpwm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [2:0] channel, [10:3] duty, rest zero
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [7:0] port_value, [8] period_start,
                                      // [9] running, rest zero
);

  logic          accept;
  mcpwm_item_t   item;
  mcpwm_result_t result;
  mcpwm_result_t out_data;

  assign accept       = s_axis_tvalid && s_axis_tready;
  assign item.mode    = mode_e'(s_axis_tuser);
  assign item.channel = s_axis_tdata[CHAN_W-1:0];
  assign item.duty    = s_axis_tdata[CHAN_W+DUTY_W-1:CHAN_W];

  mcpwm_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (accept),
    .item_i       (item),
    .result_o     (result)
  );

  mcpwm_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (result),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (out_data)
  );

  assign m_axis_tdata = {6'b0, out_data.running, out_data.period_start, out_data.port_value};

endmodule

/* dv/multi_channel_pwm_generator_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_channel_pwm_generator_test
// Self-checking bench: streams step ticks and duty writes into the generator,
// mirrors the double-buffered duty/force logic in a local model and compares
// every output transfer field by field. Both sides throttle at random, and
// the output side is held off once for a long stretch to back up the input.
// ----------------------------------------------------------------------------
module multi_channel_pwm_generator_test;
  import mcpwm_pkg::*;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        s_axis_tvalid  = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata   = '0;   // [2:0] channel, [10:3] duty, rest zero
  logic        s_axis_tuser   = 1'b0; // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready  = 1'b0;
  logic [15:0] m_axis_tdata;          // [7:0] port_value, [8] period_start,
                                      // [9] running, rest zero

  multi_channel_pwm_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shadow of the generator state
  // --------------------------------------------------------------------------
  logic [DUTY_W-1:0]   live_duty_m [CHANNELS];
  logic [DUTY_W-1:0]   next_duty_m [CHANNELS];
  logic [CHANNELS-1:0] live_act_m  = '0;
  logic [CHANNELS-1:0] next_act_m  = '0;
  logic [CHANNELS-1:0] next_hi_m   = '0;
  logic [CHANNELS-1:0] next_lo_m   = '0;
  logic                upd_wait_m  = 1'b0;
  logic [STEP_W-1:0]   step_m      = '0;
  logic [CHANNELS-1:0] pins_m      = '0;

  initial begin
    for (int c = 0; c < CHANNELS; c++) begin
      live_duty_m[c] = '0;
      next_duty_m[c] = '0;
    end
  end

  function automatic void drive_pwm_pins();
    for (int c = 0; c < CHANNELS; c++) begin
      if (live_act_m[c]) pins_m[c] = (step_m < live_duty_m[c]);
    end
  endfunction

  function automatic void load_pending_duties();
    for (int c = 0; c < CHANNELS; c++) live_duty_m[c] = next_duty_m[c];
    live_act_m = next_act_m;
    pins_m     = (pins_m & ~next_lo_m) | next_hi_m;
    next_lo_m  = '0;
    next_hi_m  = '0;
    upd_wait_m = 1'b0;
    step_m     = '0;
    drive_pwm_pins();
  endfunction

  function automatic mcpwm_result_t next_pin_result(mcpwm_item_t it);
    mcpwm_result_t       r;
    logic [CHANNELS-1:0] m;
    r.period_start = 1'b0;
    m = '0;
    m[it.channel] = 1'b1;
    if (it.mode == MODE_WRITE) begin
      if (it.duty == DUTY_FORCE_LOW || it.duty == DUTY_FORCE_HIGH) begin
        next_act_m &= ~m;
        next_duty_m[it.channel] = '0;
        if (it.duty == DUTY_FORCE_LOW) begin
          next_lo_m |= m;
          next_hi_m &= ~m;
        end else begin
          next_hi_m |= m;
          next_lo_m &= ~m;
        end
      end else begin
        next_duty_m[it.channel] = it.duty;
        next_act_m |= m;
        next_lo_m  &= ~m;
        next_hi_m  &= ~m;
      end
      upd_wait_m = 1'b1;
      // idle generator: new duties apply immediately
      if (live_act_m == '0) load_pending_duties();
    end else if (live_act_m != '0) begin
      if (int'(step_m) + 1 >= PERIOD_STEPS) begin
        r.period_start = 1'b1;
        step_m = '0;
        if (upd_wait_m) load_pending_duties();
        else drive_pwm_pins();
      end else begin
        step_m = step_m + 1'b1;
        drive_pwm_pins();
      end
    end
    r.port_value = pins_m;
    r.running    = |live_act_m;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  mcpwm_result_t pin_results_q[$];
  mcpwm_item_t   pwm_cmds_q[$];
  int            n_errors   = 0;
  int            n_accepted = 0;
  int            n_cmds     = 0;
  bit            s_taken    = 1'b0;
  bit            m_taken    = 1'b0;

  task automatic report_mismatch(string what, int got, int want);
    n_errors++;
    $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_result(logic [15:0] data);
    mcpwm_result_t want;
    if (pin_results_q.size() == 0) begin
      report_mismatch("unexpected transfer", int'(data), 0);
    end else begin
      want = pin_results_q.pop_front();
      if (data[7:0] !== want.port_value)
        report_mismatch("port_value", int'(data[7:0]), int'(want.port_value));
      if (data[8] !== want.period_start)
        report_mismatch("period_start", int'(data[8]), int'(want.period_start));
      if (data[9] !== want.running)
        report_mismatch("running", int'(data[9]), int'(want.running));
      if (data[15:10] !== '0)
        report_mismatch("tdata padding", int'(data[15:10]), 0);
    end
  endtask

  always @(posedge clk_i) begin
    mcpwm_item_t it;
    s_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    m_taken = rst_ni && m_axis_tvalid && m_axis_tready;
    if (m_taken) check_result(m_axis_tdata);
    if (s_taken) begin
      it.mode    = mode_e'(s_axis_tuser);
      it.channel = s_axis_tdata[2:0];
      it.duty    = s_axis_tdata[10:3];
      pin_results_q.push_back(next_pin_result(it));
      n_accepted++;
    end
  end

  // --------------------------------------------------------------------------
  // Throttling: random per-transfer waits, in phases with and without
  // idling. Index 0 is the input side, 1 the output side.
  // --------------------------------------------------------------------------
  int phase_left[2] = '{0, 0};
  bit no_idle[2]    = '{1'b0, 1'b0};

  function automatic int draw_wait(int side);
    if (phase_left[side] == 0) begin
      phase_left[side] = $urandom_range(10, 60);
      no_idle[side]    = ($urandom_range(0, 2) == 0);
    end
    phase_left[side]--;
    return no_idle[side] ? 0 : $urandom_range(0, 12);
  endfunction

  // input driver
  int          s_wait = 0;
  mcpwm_item_t cur_cmd;

  always @(negedge clk_i) begin
    logic nv;
    if (rst_ni) begin
      nv = s_axis_tvalid;
      if (s_axis_tvalid && s_taken) begin
        nv     = 1'b0;
        s_wait = draw_wait(0);
      end
      if (!nv) begin
        if (s_wait > 0) begin
          s_wait--;
        end else if (pwm_cmds_q.size() > 0) begin
          cur_cmd = pwm_cmds_q.pop_front();
          nv = 1'b1;
          s_axis_tdata <= {5'b0, cur_cmd.duty, cur_cmd.channel};
          s_axis_tuser <= cur_cmd.mode;
        end
      end
      s_axis_tvalid <= nv;
    end
  end

  // long output hold-off, once, after some traffic has gone through
  int n_drained = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) n_drained++;
    if (hold_left > 0) begin
      hold_left--;
    end else if (!hold_done && n_drained >= 150) begin
      hold_left = 60;
      hold_done = 1'b1;
    end
  end

  // output receiver
  int m_wait = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (m_taken) m_wait = draw_wait(1);
      else if (m_wait > 0) m_wait--;
      m_axis_tready <= (m_wait == 0) && (hold_left == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic add_cmd(mode_e md, logic [CHAN_W-1:0] ch, logic [DUTY_W-1:0] d);
    mcpwm_item_t it;
    it.mode    = md;
    it.channel = ch;
    it.duty    = d;
    pwm_cmds_q.push_back(it);
    n_cmds++;
  endtask

  // tick fields other than mode are don't-care; fill them with noise
  task automatic add_ticks(int n);
    repeat (n) add_cmd(MODE_TICK, CHAN_W'($urandom), DUTY_W'($urandom));
  endtask

  function automatic logic [DUTY_W-1:0] pick_duty();
    case ($urandom_range(0, 7))
      0:       return DUTY_FORCE_LOW;
      1:       return DUTY_FORCE_HIGH;
      2:       return ($urandom_range(0, 1) == 0) ? 8'd1 : 8'd254;
      default: return DUTY_W'($urandom);
    endcase
  endfunction

  initial begin
    int start_cnt;

    // directed part
    add_cmd(MODE_TICK, 3'd7, 8'hff);            // tick while idle: no change
    add_cmd(MODE_WRITE, 3'd0, DUTY_FORCE_HIGH); // forced high, applied at once
    add_cmd(MODE_WRITE, 3'd1, DUTY_FORCE_LOW);
    add_cmd(MODE_TICK, 3'd0, 8'h00);
    add_cmd(MODE_WRITE, 3'd7, 8'd1);            // starts the PWM at step 0
    add_ticks(2);
    add_cmd(MODE_WRITE, 3'd2, 8'd254);          // buffered until period start
    add_cmd(MODE_WRITE, 3'd3, 8'd128);
    add_cmd(MODE_WRITE, 3'd0, DUTY_FORCE_LOW);
    add_cmd(MODE_WRITE, 3'd7, DUTY_FORCE_HIGH); // removal keeps PWM until wrap
    add_cmd(MODE_WRITE, 3'd5, 8'd170);
    add_cmd(MODE_WRITE, 3'd5, DUTY_FORCE_HIGH); // overwrite of a pending write
    add_cmd(MODE_WRITE, 3'd6, 8'd85);
    add_ticks(4);

    // random part: update bursts followed by tick runs, stop-all sequences
    // that end the PWM at a period start, and raw noise
    start_cnt = n_cmds;
    while (n_cmds - start_cnt < 600) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          repeat ($urandom_range(1, 4)) add_cmd(MODE_WRITE, CHAN_W'($urandom), pick_duty());
          if ($urandom_range(0, 2) == 0) add_ticks($urandom_range(250, 262));
          else add_ticks($urandom_range(1, 20));
        end
        6, 7: begin
          for (int c = 0; c < CHANNELS; c++) begin
            add_cmd(MODE_WRITE, CHAN_W'(c),
                    ($urandom_range(0, 1) == 0) ? DUTY_FORCE_LOW : DUTY_FORCE_HIGH);
          end
          add_ticks($urandom_range(255, 262));
        end
        default: begin
          repeat ($urandom_range(1, 10)) begin
            add_cmd(mode_e'($urandom_range(0, 1)), CHAN_W'($urandom), DUTY_W'($urandom));
          end
        end
      endcase
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_cmds || pin_results_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    if (n_errors == 0 && pin_results_q.size() == 0) begin
      $display("multi_channel_pwm_generator_test passed");
    end else begin
      $display("multi_channel_pwm_generator_test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("multi_channel_pwm_generator_test failed");
    $finish;
  end

endmodule
